// File: rtl/core/lrp_pkg.sv
// ----------------------------------------------------------------------------
// Linear recurrence player package
// Shared widths, codes, sample types and control structs of the player core.
// ----------------------------------------------------------------------------
package lrp_pkg;

    localparam int MAX_ORDER   = 16;
    localparam int ADDR_W      = $clog2(MAX_ORDER);
    localparam int CNT_W       = $clog2(MAX_ORDER + 1);
    localparam int WORD_W      = 32;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int ACC_W       = PROD_W + $clog2(MAX_ORDER);
    localparam int FRAC_SHIFT  = 24;

    // Field and register widths of the port
    localparam int FUNC_W      = 2;
    localparam int INDEX_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int ORDER_W     = 5;
    localparam int SEEDS_W     = 5;
    localparam int BUDGET_W    = 16;

    // Input item functions
    localparam logic [FUNC_W-1:0] FUNC_COEF    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEED    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LATEST_VALUE = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef logic signed [WORD_W-1:0] sample_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic round_en;
    } mac_ctrl_t;

endpackage

// File: rtl/core/lrp_in_if.sv
// ----------------------------------------------------------------------------
// Linear recurrence player input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface lrp_in_if;

    logic                            valid;
    logic                            ready;
    logic [lrp_pkg::FUNC_W-1:0]      func;
    logic [lrp_pkg::INDEX_W-1:0]     index;
    logic signed [lrp_pkg::WORD_W-1:0] value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink   (input valid, input func, input index, input value, output ready);

endinterface

// File: rtl/core/lrp_out_if.sv
// ----------------------------------------------------------------------------
// Linear recurrence player output channel
// Valid/ready channel carrying one produced sample and its status.
// ----------------------------------------------------------------------------
interface lrp_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [lrp_pkg::WORD_W-1:0] sample;
    logic                              status;

    modport source (output valid, output sample, output status, input ready);
    modport sink   (input valid, input sample, input status, output ready);

endinterface

// File: rtl/core/lrp_cell.sv
// ----------------------------------------------------------------------------
// Linear recurrence player history cell
// Holds one history word; clears on restart and takes its neighbour's word,
// or the wrap-around word when it is the last active cell, on each shift.
// ----------------------------------------------------------------------------
module lrp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lrp_pkg::cell_ctrl_t ctrl,
    input  logic                active,
    input  logic                last,
    input  lrp_pkg::sample_t    neigh_in,
    input  lrp_pkg::sample_t    wrap_in,
    output lrp_pkg::sample_t    q
);

    lrp_pkg::sample_t word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            word_reg <= '0;
        end
        else if (ctrl.shift && active)
        begin
            word_reg <= last ? wrap_in : neigh_in;
        end
    end

    assign q = word_reg;

endmodule

// File: rtl/core/lrp_mac.sv
// ----------------------------------------------------------------------------
// Linear recurrence player multiply-accumulate unit
// One registered 32x32 product per cycle into an exact accumulator, then a
// negate-and-round stage and a saturation to a Q16.16 word.
// ----------------------------------------------------------------------------
module lrp_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  lrp_pkg::mac_ctrl_t ctrl,
    input  lrp_pkg::sample_t   coef,
    input  lrp_pkg::sample_t   tap,
    output logic               busy,
    output lrp_pkg::sample_t   sample
);

    localparam int RND_W = lrp_pkg::ACC_W + 1;
    localparam int SHF_W = RND_W - lrp_pkg::FRAC_SHIFT;
    localparam int TOP_W = SHF_W - lrp_pkg::WORD_W + 1;
    localparam logic signed [RND_W-1:0] RND_HALF =
        RND_W'(1) << (lrp_pkg::FRAC_SHIFT - 1);

    logic signed [lrp_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_v_reg;
    logic signed [lrp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [RND_W-1:0]           rnd_reg;
    logic [SHF_W-1:0]                  shf;
    logic [TOP_W-1:0]                  top_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * tap;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + lrp_pkg::ACC_W'(prod_reg);
        end
        if (ctrl.round_en)
        begin
            rnd_reg <= RND_HALF - RND_W'(acc_reg);
        end
    end

    // Arithmetic shift by the coefficient fraction, then clamp to 32 bits
    assign shf      = rnd_reg[RND_W-1:lrp_pkg::FRAC_SHIFT];
    assign top_bits = shf[SHF_W-1:lrp_pkg::WORD_W-1];

    always_comb
    begin
        if ((top_bits == '0) || (top_bits == '1))
        begin
            sample = $signed(shf[lrp_pkg::WORD_W-1:0]);
        end
        else if (shf[SHF_W-1])
        begin
            sample = {1'b1, {(lrp_pkg::WORD_W-1){1'b0}}};
        end
        else
        begin
            sample = {1'b0, {(lrp_pkg::WORD_W-1){1'b1}}};
        end
    end

    assign busy = prod_v_reg;

endmodule

// File: rtl/core/linear_recurrence_player_unit.sv
// ----------------------------------------------------------------------------
// Linear recurrence player unit
// Plays back seed words and then a linear recurrence over a chain of
// history cells, using one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Sequencing: a table write lands at its accepting edge; a restart keeps the input closed
// while ST_RST fills the history cells from the seed table. A next result is registered
// straight from ST_IDLE for the latest value or a refusal, in ST_SEED for a seed, and in
// ST_SAT for a recurrence value, after the MAC walk over one history tap per cycle.
// One transaction at a time: the input reopens the cycle after the output is registered.
// Reset clears the history cells, counters and control registers and sets the seed count to one; tables are unset.
// ----------------------------------------------------------------------------
module linear_recurrence_player_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    lrp_in_if.sink                              in_ch,
    lrp_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [lrp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lrp_pkg::WORD_W-1:0]          cfg_data
);

    localparam int MAXO   = lrp_pkg::MAX_ORDER;
    localparam int ADDR_W = lrp_pkg::ADDR_W;
    localparam int CNT_W  = lrp_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RST    = 3'd1;
    localparam logic [2:0] ST_SEED   = 3'd2;
    localparam logic [2:0] ST_MAC    = 3'd3;
    localparam logic [2:0] ST_ROUND  = 3'd4;
    localparam logic [2:0] ST_SAT    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    // Configuration registers
    logic [lrp_pkg::ORDER_W-1:0]  order_reg;
    logic [lrp_pkg::SEEDS_W-1:0]  seed_count_reg;
    logic [lrp_pkg::BUDGET_W-1:0] sample_count_reg;
    lrp_pkg::sample_t             latest_value_reg;

    // Control
    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             emitted_reg;
    logic [lrp_pkg::BUDGET_W-1:0] budget_reg;
    logic                         playing_reg;
    logic                         pend_v_reg;
    logic                         pend_zero_reg;
    logic                         v1_reg;
    lrp_pkg::sample_t             tap_reg;
    lrp_pkg::sample_t             res_sample_reg;
    logic                         res_status_reg;
    logic                         out_valid_reg;
    lrp_pkg::sample_t             out_sample_reg;
    logic                         out_status_reg;

    // Tables
    lrp_pkg::sample_t             coef_mem [MAXO];
    lrp_pkg::sample_t             seed_mem [MAXO];
    lrp_pkg::sample_t             coef_rd_reg;
    lrp_pkg::sample_t             seed_rd_reg;
    logic [ADDR_W-1:0]            coef_raddr;
    logic [ADDR_W-1:0]            seed_raddr;

    logic [CNT_W-1:0]             ord_c;
    logic [CNT_W-1:0]             sc_c;
    logic [CNT_W:0]               fill_sum;
    logic                         in_fire;
    logic                         issue;
    logic                         is_restart;
    logic                         can_emit;

    lrp_pkg::sample_t             hist [MAXO];
    lrp_pkg::sample_t             wrap_value;
    lrp_pkg::cell_ctrl_t          cell_ctrl;
    lrp_pkg::mac_ctrl_t           mac_ctrl;
    logic                         mac_busy;
    lrp_pkg::sample_t             mac_sample;

    assign ord_c = (32'(order_reg) > MAXO) ? CNT_W'(MAXO) : CNT_W'(order_reg);
    assign sc_c  = (32'(seed_count_reg) > MAXO) ? CNT_W'(MAXO) : CNT_W'(seed_count_reg);

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_restart  = in_fire && (in_ch.func == lrp_pkg::FUNC_RESTART) && (sc_c != '0);
    assign can_emit    = (out_valid_reg == 1'b0) || out_ch.ready;
    assign issue       = (state_reg == ST_MAC) && (cnt_reg < ord_c);

    // Restart fill: history word i takes seed sc+i-order, or zero when short
    assign fill_sum   = {1'b0, sc_c} + {1'b0, cnt_reg};
    assign seed_raddr = (state_reg == ST_RST) ? ADDR_W'(fill_sum - {1'b0, ord_c})
                                              : emitted_reg[ADDR_W-1:0];
    assign coef_raddr = ADDR_W'(ord_c - CNT_W'(1) - cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg        <= '0;
            seed_count_reg   <= lrp_pkg::SEEDS_W'(1);
            sample_count_reg <= '0;
            latest_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrp_pkg::REG_ORDER:        order_reg        <= cfg_data[lrp_pkg::ORDER_W-1:0];
                lrp_pkg::REG_SEED_COUNT:   seed_count_reg   <= cfg_data[lrp_pkg::SEEDS_W-1:0];
                lrp_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[lrp_pkg::BUDGET_W-1:0];
                lrp_pkg::REG_LATEST_VALUE: latest_value_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Tables: one write and one registered read each per cycle
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_ch.func == lrp_pkg::FUNC_COEF)
            && (in_ch.index != '0) && (32'(in_ch.index) <= MAXO))
        begin
            coef_mem[ADDR_W'(32'(in_ch.index) - 1)] <= in_ch.value;
        end
        if (in_fire && (in_ch.func == lrp_pkg::FUNC_SEED) && (32'(in_ch.index) < MAXO))
        begin
            seed_mem[ADDR_W'(in_ch.index)] <= in_ch.value;
        end
        coef_rd_reg <= coef_mem[coef_raddr];
        seed_rd_reg <= seed_mem[seed_raddr];
        if (issue)
        begin
            tap_reg <= hist[0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.func)
                        lrp_pkg::FUNC_RESTART:
                        begin
                            if (sc_c != '0)
                            begin
                                state_next = ST_RST;
                            end
                        end
                        lrp_pkg::FUNC_NEXT:
                        begin
                            if (!playing_reg || (budget_reg == '0))
                            begin
                                state_next = ST_FINISH;
                            end
                            else if (emitted_reg < sc_c)
                            begin
                                state_next = ST_SEED;
                            end
                            else if (ord_c == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RST:
            begin
                if ((cnt_reg == ord_c) && !pend_v_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEED:   state_next = ST_FINISH;
            ST_MAC:
            begin
                if ((cnt_reg == ord_c) && !v1_reg && !mac_busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:  state_next = ST_SAT;
            ST_SAT:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            emitted_reg    <= '0;
            budget_reg     <= '0;
            playing_reg    <= 1'b0;
            pend_v_reg     <= 1'b0;
            pend_zero_reg  <= 1'b0;
            v1_reg         <= 1'b0;
            res_sample_reg <= '0;
            res_status_reg <= lrp_pkg::STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_status_reg <= lrp_pkg::STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;

            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg    <= '0;
                    pend_v_reg <= 1'b0;
                    if (in_fire && (in_ch.func == lrp_pkg::FUNC_RESTART))
                    begin
                        if (sc_c == '0)
                        begin
                            playing_reg <= 1'b0;
                        end
                        else
                        begin
                            emitted_reg <= '0;
                            budget_reg  <= sample_count_reg;
                            playing_reg <= 1'b1;
                        end
                    end
                    else if (in_fire && (in_ch.func == lrp_pkg::FUNC_NEXT))
                    begin
                        if (!playing_reg || (budget_reg == '0))
                        begin
                            res_sample_reg <= '0;
                            res_status_reg <= lrp_pkg::STATUS_REFUSED;
                        end
                        else
                        begin
                            // Hold the emitted count once it reaches the seed table depth
                            if (32'(emitted_reg) < MAXO)
                            begin
                                emitted_reg <= emitted_reg + CNT_W'(1);
                            end
                            budget_reg     <= budget_reg - lrp_pkg::BUDGET_W'(1);
                            res_sample_reg <= latest_value_reg;
                            res_status_reg <= lrp_pkg::STATUS_OK;
                        end
                    end
                end
                ST_RST:
                begin
                    if (cnt_reg < ord_c)
                    begin
                        cnt_reg       <= cnt_reg + CNT_W'(1);
                        pend_v_reg    <= 1'b1;
                        pend_zero_reg <= (fill_sum < {1'b0, ord_c});
                    end
                    else
                    begin
                        pend_v_reg <= 1'b0;
                    end
                end
                ST_SEED:
                begin
                    res_sample_reg <= seed_rd_reg;
                end
                ST_MAC:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_SAT:
                begin
                    res_sample_reg <= mac_sample;
                end
                default: ;
            endcase

            if ((state_reg == ST_FINISH) && can_emit)
            begin
                out_valid_reg  <= 1'b1;
                out_sample_reg <= res_sample_reg;
                out_status_reg <= res_status_reg;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.sample = out_sample_reg;
    assign out_ch.status = out_status_reg;

    // History chain: rotate during the MAC walk, insert on fill and on result
    always_comb
    begin
        case (state_reg)
            ST_RST:  wrap_value = pend_zero_reg ? '0 : seed_rd_reg;
            ST_SAT:  wrap_value = mac_sample;
            default: wrap_value = hist[0];
        endcase
    end

    assign cell_ctrl.clear = is_restart;
    assign cell_ctrl.shift = issue || ((state_reg == ST_RST) && pend_v_reg)
                             || (state_reg == ST_SAT);

    for (genvar i = 0; i < MAXO; i++)
    begin : g_cell
        lrp_pkg::sample_t neigh;
        if (i == MAXO - 1)
        begin : g_end
            assign neigh = wrap_value;
        end
        else
        begin : g_mid
            assign neigh = hist[i + 1];
        end

        lrp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .active   (CNT_W'(i) < ord_c),
            .last     (CNT_W'(i + 1) == ord_c),
            .neigh_in (neigh),
            .wrap_in  (wrap_value),
            .q        (hist[i])
        );
    end

    assign mac_ctrl.clear    = (state_reg == ST_IDLE);
    assign mac_ctrl.mul_en   = v1_reg;
    assign mac_ctrl.round_en = (state_reg == ST_ROUND);

    lrp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (coef_rd_reg),
        .tap    (tap_reg),
        .busy   (mac_busy),
        .sample (mac_sample)
    );

    a_mac_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (cnt_reg <= ord_c))
        else $error("MAC walk issued past the recurrence order");

    a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (!v1_reg && !mac_busy))
        else $error("rounding started before the MAC pipeline drained");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == lrp_pkg::STATUS_REFUSED))
        |-> (out_sample_reg == '0))
        else $error("refused transaction carries a non-zero sample");

    a_restart_arm: assert property (@(posedge clk) disable iff (!rst_n)
        is_restart |=> (playing_reg && (budget_reg == $past(sample_count_reg))
                        && (emitted_reg == '0)))
        else $error("restart did not arm the playback");

endmodule
